// ----- rtl/hll_pkg.sv -----
// ----------------------------------------------------------------------------
// hll_pkg
// Shared constants, types and helper functions of the rank-register sketch.
// ----------------------------------------------------------------------------
package hll_pkg;

    localparam int MAX_INDEX_BITS  = 12;
    localparam int DENSE_LEVELS    = 4;
    localparam int OVERFLOW_LEVELS = 3;
    localparam int SUM_FRAC_BITS   = 7;

    localparam int HASH_W     = 64;
    localparam int CFG_W      = 4;
    localparam int RANK_CAP   = DENSE_LEVELS + OVERFLOW_LEVELS;
    localparam int RANK_W     = $clog2(RANK_CAP + 1);
    // only the top bits can decide a capped rank
    localparam int PROBE_BITS = RANK_CAP - 1;
    localparam int IDX_W      = MAX_INDEX_BITS;
    localparam int BUCKETS    = 1 << MAX_INDEX_BITS;
    localparam int SUM_W      = 19;
    localparam int EMPTY_W    = 13;
    localparam int CONTRIB_W  = SUM_FRAC_BITS;
    localparam int OUT_W      = 32;

    localparam logic [CFG_W-1:0] INDEX_BITS_RESET = CFG_W'(12);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        OP_ADD = 1'b0,
        OP_SUM = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [RANK_W-1:0] rank;
    } item_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SUM_RD,
        ST_SUM_LAST,
        ST_SUM_OUT
    } back_state_t;

    typedef struct packed
    {
        logic clearing;
        logic summing;
    } back_stat_t;

    // leading-zero count of the top bits plus one, saturated at the cap
    function automatic logic [RANK_W-1:0] rank_of(input logic [PROBE_BITS-1:0] top);
        logic [RANK_W-1:0] r;
        r = RANK_W'(RANK_CAP);
        for (int i = PROBE_BITS - 1; i >= 0; i--)
        begin
            if (top[PROBE_BITS-1-i])
            begin
                r = RANK_W'(i + 1);
            end
        end
        return r;
    endfunction

    // 2^-rank in units of 2^-SUM_FRAC_BITS, empty bucket counts as rank 1
    function automatic logic [CONTRIB_W-1:0] contrib(input logic [RANK_W-1:0] rank);
        logic [RANK_W-1:0]    r;
        logic [CONTRIB_W-1:0] c;
        r = (rank == '0) ? RANK_W'(1) : rank;
        c = '0;
        if (int'(r) <= SUM_FRAC_BITS)
        begin
            c = CONTRIB_W'(1) << (SUM_FRAC_BITS - int'(r));
        end
        return c;
    endfunction

endpackage

// ----- rtl/hll_front.sv -----
// ----------------------------------------------------------------------------
// hll_front
// Input stage: takes stream transactions and turns them into queue items.
// ----------------------------------------------------------------------------
module hll_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hll_pkg::HASH_W-1:0]   s_tdata,
    input  logic [0:0]                   s_tuser,
    input  logic [hll_pkg::IDX_W-1:0]    idx_mask,
    input  logic                         clearing,
    output logic                         q_valid,
    input  logic                         q_ready,
    output hll_pkg::item_t               q_item
);

    logic           fr_valid_reg;
    logic           fr_valid_next;
    hll_pkg::item_t fr_item_reg;
    hll_pkg::item_t fr_item_new;
    logic           take;

    assign s_tready = !clearing && (!fr_valid_reg || q_ready);
    assign take     = s_tvalid && s_tready;
    assign q_valid  = fr_valid_reg;
    assign q_item   = fr_item_reg;

    always_comb
    begin
        fr_item_new.op   = hll_pkg::op_t'(s_tuser[0]);
        fr_item_new.idx  = s_tdata[hll_pkg::IDX_W-1:0] & idx_mask;
        fr_item_new.rank = hll_pkg::rank_of(
            s_tdata[hll_pkg::HASH_W-1 -: hll_pkg::PROBE_BITS]);
        fr_valid_next    = take || (fr_valid_reg && !q_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fr_item_reg <= fr_item_new;
        end
    end

endmodule

// ----- rtl/hll_queue.sv -----
// ----------------------------------------------------------------------------
// hll_queue
// Short item queue between the input stage and the bucket sequencer.
// ----------------------------------------------------------------------------
module hll_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hll_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output hll_pkg::item_t out_item
);

    hll_pkg::item_t              q_mem [hll_pkg::QUEUE_DEPTH];
    logic [hll_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [hll_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [hll_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [hll_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [hll_pkg::QCNT_W-1:0]  cnt_reg;
    logic [hll_pkg::QCNT_W-1:0]  cnt_next;
    logic                        push;
    logic                        pop;

    assign in_ready  = (cnt_reg != hll_pkg::QCNT_W'(hll_pkg::QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = q_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == hll_pkg::QPTR_W'(hll_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == hll_pkg::QPTR_W'(hll_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/hll_back.sv -----
// ----------------------------------------------------------------------------
// hll_back
// Bucket sequencer: rank memory, clear pass, rank update and summary walk.
// ----------------------------------------------------------------------------
module hll_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  hll_pkg::item_t                q_item,
    input  logic [hll_pkg::IDX_W-1:0]     idx_mask,
    output hll_pkg::back_stat_t           stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hll_pkg::OUT_W-1:0]     m_tdata
);

    logic [hll_pkg::RANK_W-1:0]  bucket_mem [hll_pkg::BUCKETS];

    hll_pkg::back_state_t        state_reg;
    hll_pkg::back_state_t        state_next;
    logic [hll_pkg::IDX_W-1:0]   walk_reg;
    logic [hll_pkg::IDX_W-1:0]   walk_next;
    hll_pkg::item_t              cur_reg;
    logic                        cur_load;
    logic                        rd_pend_reg;
    logic                        rd_pend_next;
    logic [hll_pkg::RANK_W-1:0]  rdata_reg;
    logic [hll_pkg::IDX_W-1:0]   raddr;
    logic                        we;
    logic [hll_pkg::IDX_W-1:0]   waddr;
    logic [hll_pkg::RANK_W-1:0]  wdata;
    logic [hll_pkg::SUM_W-1:0]   sum_reg;
    logic [hll_pkg::SUM_W-1:0]   sum_next;
    logic [hll_pkg::EMPTY_W-1:0] empty_reg;
    logic [hll_pkg::EMPTY_W-1:0] empty_next;
    logic                        acc_clear;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [hll_pkg::OUT_W-1:0]   m_data_reg;
    logic                        out_load;
    logic                        out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign stat.clearing = (state_reg == hll_pkg::ST_CLEAR);
    assign stat.summing  = (state_reg == hll_pkg::ST_SUM_RD)
                        || (state_reg == hll_pkg::ST_SUM_LAST)
                        || (state_reg == hll_pkg::ST_SUM_OUT);

    always_comb
    begin
        state_next   = state_reg;
        walk_next    = walk_reg;
        cur_load     = 1'b0;
        q_ready      = 1'b0;
        rd_pend_next = 1'b0;
        raddr        = walk_reg;
        we           = 1'b0;
        waddr        = walk_reg;
        wdata        = '0;
        acc_clear    = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            hll_pkg::ST_CLEAR:
            begin
                we = 1'b1;
                if (walk_reg == '1)
                begin
                    state_next = hll_pkg::ST_IDLE;
                end
                walk_next = walk_reg + 1'b1;
            end
            hll_pkg::ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    cur_load = 1'b1;
                    if (q_item.op == hll_pkg::OP_SUM)
                    begin
                        walk_next  = '0;
                        acc_clear  = 1'b1;
                        state_next = hll_pkg::ST_SUM_RD;
                    end
                    else
                    begin
                        state_next = hll_pkg::ST_ADD_RD;
                    end
                end
            end
            hll_pkg::ST_ADD_RD:
            begin
                raddr      = cur_reg.idx;
                state_next = hll_pkg::ST_ADD_WR;
            end
            hll_pkg::ST_ADD_WR:
            begin
                waddr      = cur_reg.idx;
                wdata      = cur_reg.rank;
                we         = (cur_reg.rank > rdata_reg);
                state_next = hll_pkg::ST_IDLE;
            end
            hll_pkg::ST_SUM_RD:
            begin
                rd_pend_next = 1'b1;
                walk_next    = walk_reg + 1'b1;
                if (walk_reg == idx_mask)
                begin
                    state_next = hll_pkg::ST_SUM_LAST;
                end
            end
            hll_pkg::ST_SUM_LAST:
            begin
                // last read data is added at the end of this cycle
                state_next = hll_pkg::ST_SUM_OUT;
            end
            hll_pkg::ST_SUM_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = hll_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hll_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sum_next   = sum_reg;
        empty_next = empty_reg;
        if (acc_clear)
        begin
            sum_next   = '0;
            empty_next = '0;
        end
        else if (rd_pend_reg)
        begin
            sum_next = sum_reg + hll_pkg::SUM_W'(hll_pkg::contrib(rdata_reg));
            if (rdata_reg == '0)
            begin
                empty_next = empty_reg + 1'b1;
            end
        end
        m_valid_next = out_load || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hll_pkg::ST_CLEAR;
            walk_reg    <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            walk_reg    <= walk_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        empty_reg <= empty_next;
        if (cur_load)
        begin
            cur_reg <= q_item;
        end
        if (out_load)
        begin
            m_data_reg <= {empty_reg, sum_reg};
        end
    end

    // rank memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            bucket_mem[waddr] <= wdata;
        end
        rdata_reg <= bucket_mem[raddr];
    end

endmodule

// ----- rtl/hll_register_update_and_sum_top.sv -----
// ----------------------------------------------------------------------------
// hll_register_update_and_sum_top
// HyperLogLog rank-register sketch with a harmonic-sum readout.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser selects the operation (0 add, 1 summarize) and
// s_tdata carries the 64-bit hash. An add keeps the larger of the stored rank
// and the new rank in the bucket picked by the low index bits; it gives no
// output. A summarize walks the active buckets and returns one transaction on
// m_*: m_tdata holds the harmonic sum (units of 2^-7) and the empty count.
// cfg_we/cfg_wdata set the number of index bits (values above 12 act as 12);
// write it only while the block is idle.
// An add goes through the issue, read and conditional write steps on the
// rank memory. A summarize reads one bucket per cycle, then waits for the
// output stage to be free before it hands over the result.
// After reset all 4096 buckets of the rank memory are cleared one per cycle
// with s_tready low; cfg writes are still taken. A stalled receiver holds the
// result in the output register; the input stage and a two-entry queue keep
// taking items until they fill.
// ----------------------------------------------------------------------------
module hll_register_update_and_sum_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hll_pkg::HASH_W-1:0]     s_tdata,   // hash_value
    input  logic [0:0]                     s_tuser,   // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hll_pkg::OUT_W-1:0]      m_tdata,   // harmonic_sum, empty_count
    input  logic                           cfg_we,
    input  logic [hll_pkg::CFG_W-1:0]      cfg_wdata
);

    logic [hll_pkg::CFG_W-1:0] index_bits_reg;
    logic [hll_pkg::CFG_W-1:0] index_bits_next;
    logic [hll_pkg::CFG_W-1:0] ib_active;
    logic [hll_pkg::IDX_W-1:0] idx_mask;
    logic                      q_in_valid;
    logic                      q_in_ready;
    hll_pkg::item_t            q_in_item;
    logic                      q_out_valid;
    logic                      q_out_ready;
    hll_pkg::item_t            q_out_item;
    hll_pkg::back_stat_t       back_stat;

    always_comb
    begin
        index_bits_next = cfg_we ? cfg_wdata : index_bits_reg;
        ib_active = (index_bits_reg > hll_pkg::CFG_W'(hll_pkg::MAX_INDEX_BITS)) ?
                    hll_pkg::CFG_W'(hll_pkg::MAX_INDEX_BITS) : index_bits_reg;
        for (int b = 0; b < hll_pkg::IDX_W; b++)
        begin
            idx_mask[b] = (b < int'(ib_active));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg <= hll_pkg::INDEX_BITS_RESET;
        end
        else
        begin
            index_bits_reg <= index_bits_next;
        end
    end

    hll_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .idx_mask (idx_mask),
        .clearing (back_stat.clearing),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_item   (q_in_item)
    );

    hll_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_item   (q_in_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_item  (q_out_item)
    );

    hll_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_out_valid),
        .q_ready  (q_out_ready),
        .q_item   (q_out_item),
        .idx_mask (idx_mask),
        .stat     (back_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTH
    // no transaction is taken while the rank memory is being cleared
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.clearing |-> !s_tready)
        else $error("input taken during clear pass");

    // a result only appears at the end of a summary walk
    a_result_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(back_stat.summing))
        else $error("result without summary walk");

    // clear pass never overlaps a pending result
    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.clearing |-> !m_tvalid)
        else $error("result valid during clear pass");
`endif

endmodule

// ----- tb/hll_sketch_checker.sv -----
// ----------------------------------------------------------------------------
// hll_sketch_checker
// Watches the hash stream, the config port and the readout stream of the
// rank-register sketch. It keeps its own copy of the bucket ranks and the index
// width, predicts each harmonic-sum readout and compares it field by field.
// ----------------------------------------------------------------------------
module hll_sketch_checker
    import hll_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [HASH_W-1:0] s_tdata,   // hash_value
    input  logic [0:0]        s_tuser,   // op
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,   // harmonic_sum, empty_count
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic [SUM_W-1:0]   harmonic_sum;
        logic [EMPTY_W-1:0] empty_count;
    } readout_t;

    logic [RANK_W-1:0] rank_store [BUCKETS];
    logic [CFG_W-1:0]  index_bits;
    readout_t          readout_q [$];
    int                fails;

    function automatic int active_bits();
        return (int'(index_bits) > MAX_INDEX_BITS) ? MAX_INDEX_BITS : int'(index_bits);
    endfunction

    // leading zeros of the bits above the index, plus one, capped
    function automatic logic [RANK_W-1:0] hash_rank(input logic [HASH_W-1:0] h, input int ib);
        int zeros;
        int r;
        zeros = 0;
        while (zeros < HASH_W - ib && !h[HASH_W-1-zeros])
        begin
            zeros++;
        end
        r = zeros + 1;
        if (r > RANK_CAP)
        begin
            r = RANK_CAP;
        end
        return RANK_W'(r);
    endfunction

    function automatic readout_t walk_buckets(input int ib);
        readout_t ro;
        int       total;
        int       empties;
        int       r;
        total   = 0;
        empties = 0;
        for (int i = 0; i < (1 << ib); i++)
        begin
            r = int'(rank_store[i]);
            // an empty bucket still weighs as rank 1
            if (r == 0)
            begin
                empties++;
                r = 1;
            end
            if (r <= SUM_FRAC_BITS)
            begin
                total += 1 << (SUM_FRAC_BITS - r);
            end
        end
        ro.harmonic_sum = SUM_W'(total);
        ro.empty_count  = EMPTY_W'(empties);
        return ro;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        readout_t          got;
        readout_t          want;
        int                ib;
        logic [IDX_W-1:0]  idx;
        logic [RANK_W-1:0] rk;
        if (!rst_n)
        begin
            foreach (rank_store[i])
            begin
                rank_store[i] = '0;
            end
            index_bits = INDEX_BITS_RESET;
            readout_q.delete();
            fails = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.harmonic_sum = m_tdata[SUM_W-1:0];
                got.empty_count  = m_tdata[SUM_W +: EMPTY_W];
                if (readout_q.size() == 0)
                begin
                    $error("unexpected readout transaction: harmonic_sum %0d, empty_count %0d",
                           got.harmonic_sum, got.empty_count);
                    fails++;
                end
                else
                begin
                    want = readout_q.pop_front();
                    if (got.harmonic_sum !== want.harmonic_sum)
                    begin
                        $error("harmonic_sum mismatch: expected %0d, actual %0d",
                               want.harmonic_sum, got.harmonic_sum);
                        fails++;
                    end
                    if (got.empty_count !== want.empty_count)
                    begin
                        $error("empty_count mismatch: expected %0d, actual %0d",
                               want.empty_count, got.empty_count);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                ib = active_bits();
                if (op_t'(s_tuser[0]) == OP_SUM)
                begin
                    readout_q.push_back(walk_buckets(ib));
                end
                else
                begin
                    idx = IDX_W'(s_tdata) & IDX_W'((1 << ib) - 1);
                    rk  = hash_rank(s_tdata, ib);
                    if (rk > rank_store[idx])
                    begin
                        rank_store[idx] = rk;
                    end
                end
            end
            if (cfg_we)
            begin
                index_bits = cfg_wdata;
            end
        end
        fail_count <= fails;
        pending    <= readout_q.size();
    end

endmodule

// ----- tb/tb_hll_register_update_and_sum_top.sv -----
// ----------------------------------------------------------------------------
// tb_hll_register_update_and_sum_top
// Drives adds and summaries into the rank-register sketch over a range of
// index widths, with random stalls on both streams in most phases; the checker predicts and
// compares every readout and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_hll_register_update_and_sum_top;
    import hll_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [HASH_W-1:0] s_tdata   = '0;   // hash_value
    logic [0:0]        s_tuser   = '0;   // op
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;          // harmonic_sum, empty_count
    logic              cfg_we    = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 27;
    int recv_idle_pct = 60;
    int adds_sent     = 0;
    int sums_sent     = 0;
    int cfg_writes    = 0;

    hll_register_update_and_sum_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    hll_sketch_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input op_t op, input logic [HASH_W-1:0] hash);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= hash;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        if (op == OP_SUM)
        begin
            sums_sent++;
        end
        else
        begin
            adds_sent++;
        end
    endtask

    // hold the stream until every readout is back, then let queued adds retire
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (32) @(posedge clk);
    endtask

    task automatic set_index_bits(input logic [CFG_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // shifting right now and then gives long runs of leading zeros
    function automatic logic [HASH_W-1:0] random_hash();
        logic [HASH_W-1:0] h;
        h = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
        begin
            h = h >> $urandom_range(12);
        end
        return h;
    endfunction

    initial
    begin : stimulus
        logic [CFG_W-1:0] widths [8];
        int               sum_pct;
        widths = '{CFG_W'(3), CFG_W'(0), CFG_W'(12), CFG_W'(15),
                   CFG_W'(7), CFG_W'(1), CFG_W'(5), CFG_W'(10)};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // full-width index straight after the clearing pass
        send_item(OP_SUM, '1);
        send_item(OP_ADD, 64'h0000_0000_0000_0000);
        send_item(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_ADD, 64'h8000_0000_0000_0123);
        send_item(OP_ADD, 64'h0400_0000_0000_0123);
        send_item(OP_ADD, 64'h4000_0000_0000_0123);
        send_item(OP_ADD, 64'h0000_0100_0000_0ABC);
        send_item(OP_SUM, '0);
        // single bucket, rank taken over all hash bits
        set_index_bits(CFG_W'(0));
        send_item(OP_ADD, 64'h0000_0000_0000_0001);
        send_item(OP_ADD, 64'hC000_0000_0000_0000);
        send_item(OP_SUM, '0);
        // width beyond the maximum acts as the maximum
        set_index_bits(CFG_W'(15));
        send_item(OP_ADD, 64'h2000_0000_0000_0FFF);
        send_item(OP_ADD, 64'h0000_0000_0000_1000);
        send_item(OP_SUM, '0);

        for (int p = 0; p < 8; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 27;
            end
            else if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_index_bits(widths[p]);
            // full walks are long at wide indexes, so keep them rare there
            sum_pct = (widths[p] >= CFG_W'(10)) ? 1 : 9;
            repeat (250)
            begin
                send_item(($urandom_range(99) < sum_pct) ? OP_SUM : OP_ADD, random_hash());
            end
        end
        settle();

        $display("covered %0d adds and %0d summaries over %0d index-width writes",
                 adds_sent, sums_sent, cfg_writes);
        $display("stalls on sender and receiver in both weightings, then free-running");
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #(150_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
